/* hdl/clock_and_countdown_timer_unit_assert.svh */
// assertion macros used by the checker file
`ifndef CLOCK_AND_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define CLOCK_AND_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CDT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cdt assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cdt assertion failed");

`endif

/* hdl/cdt_pkg.sv */
`timescale 1ns / 1ps
package cdt_pkg;

	localparam int unsigned TICK_W = 16;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [TICK_W-1:0] TPS_RESET = 16'd3000;

	localparam logic [CFG_IDX_W-1:0] CFG_TPS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FMT24 = 8'd1;

	localparam logic [2:0] TGT_CLK_H = 3'd0;
	localparam logic [2:0] TGT_CLK_M = 3'd1;
	localparam logic [2:0] TGT_CLK_S = 3'd2;
	localparam logic [2:0] TGT_TMR_H = 3'd3;
	localparam logic [2:0] TGT_TMR_M = 3'd4;
	localparam logic [2:0] TGT_TMR_S = 3'd5;

	localparam logic [1:0] UNIT_H = 2'd0;
	localparam logic [1:0] UNIT_M = 2'd1;
	localparam logic [1:0] UNIT_S = 2'd2;

	localparam logic [6:0] CLK_HMOD = 7'd24;
	localparam logic [6:0] TMR_HMOD = 7'd100;
	localparam logic [5:0] MS_MAX = 6'd59;
	localparam logic [4:0] NOON = 5'd12;

	typedef enum logic [2:0] {
		KIND_TICK,
		KIND_UP,
		KIND_DOWN,
		KIND_RUN,
		KIND_PAUSE,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		logic [6:0] h;
		logic [5:0] m;
		logic [5:0] s;
	} hms_t;

	typedef struct packed {
		logic       expired;
		logic       running;
		logic [5:0] rem_s;
		logic [5:0] rem_m;
		logic [6:0] rem_h;
		logic [5:0] clk_s;
		logic [5:0] clk_m;
		logic       pm;
		logic [4:0] shown_h;
	} result_t;

	// step one unit of h:m:s up or down, carrying into the higher units
	function automatic hms_t step_chain(hms_t t, logic [6:0] hmod, logic [1:0] unit,
			logic up);
		hms_t r;
		logic carry;
		logic [7:0] h_inc;
		r = t;
		carry = 1'b1;
		h_inc = {1'b0, t.h} + 8'd1;
		if (unit >= UNIT_S) begin
			if (up) begin
				if (r.s >= MS_MAX) begin
					r.s = 6'd0;
				end else begin
					r.s = r.s + 6'd1;
					carry = 1'b0;
				end
			end else begin
				if (r.s == 6'd0 || r.s > MS_MAX) begin
					r.s = MS_MAX;
				end else begin
					r.s = r.s - 6'd1;
					carry = 1'b0;
				end
			end
		end
		if (unit >= UNIT_M && carry) begin
			if (up) begin
				if (r.m >= MS_MAX) begin
					r.m = 6'd0;
				end else begin
					r.m = r.m + 6'd1;
					carry = 1'b0;
				end
			end else begin
				if (r.m == 6'd0 || r.m > MS_MAX) begin
					r.m = MS_MAX;
				end else begin
					r.m = r.m - 6'd1;
					carry = 1'b0;
				end
			end
		end
		if (carry) begin
			if (up) begin
				r.h = (h_inc >= {1'b0, hmod}) ? 7'd0 : h_inc[6:0];
			end else begin
				r.h = (r.h == 7'd0 || r.h >= hmod) ? hmod - 7'd1 : r.h - 7'd1;
			end
		end
		return r;
	endfunction

endpackage

/* hdl/cdt_core.sv */
`timescale 1ns / 1ps
module cdt_core import cdt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [TICK_W-1:0]    cfg_wdata,
	input  logic                 in_fire,
	input  logic [2:0]           in_kind,
	input  logic [2:0]           in_target,
	output result_t              res
);

	logic [TICK_W-1:0] tps_q;
	logic              fmt24_q;
	logic [TICK_W-1:0] tick_q;
	hms_t              clk_q;
	hms_t              tmr_q;
	logic              active_q;

	logic [TICK_W-1:0] tick_d;
	hms_t              clk_d;
	hms_t              tmr_d;
	logic              active_d;
	logic              expired;
	logic [TICK_W:0]   tick_inc;
	logic [2:0]        tmr_unit;
	logic              tmr_zero;

	assign tick_inc = {1'b0, tick_q} + {{TICK_W{1'b0}}, 1'b1};
	assign tmr_unit = in_target - TGT_TMR_H;
	assign tmr_zero = (tmr_q == '0);

	always_comb begin
		tick_d = tick_q;
		clk_d = clk_q;
		tmr_d = tmr_q;
		active_d = active_q;
		expired = 1'b0;
		case (kind_t'(in_kind))
			KIND_TICK: begin
				if (tick_inc >= {1'b0, tps_q}) begin
					tick_d = '0;
					clk_d = step_chain(clk_q, CLK_HMOD, UNIT_S, 1'b1);
					if (active_q) begin
						if (tmr_zero) begin
							active_d = 1'b0;
							expired = 1'b1;
						end else begin
							tmr_d = step_chain(tmr_q, TMR_HMOD, UNIT_S, 1'b0);
						end
					end
				end else begin
					tick_d = tick_inc[TICK_W-1:0];
				end
			end
			KIND_UP, KIND_DOWN: begin
				if (in_target <= TGT_CLK_S) begin
					clk_d = step_chain(clk_q, CLK_HMOD, in_target[1:0],
						kind_t'(in_kind) == KIND_UP);
				end else if (in_target <= TGT_TMR_S) begin
					tmr_d = step_chain(tmr_q, TMR_HMOD, tmr_unit[1:0],
						kind_t'(in_kind) == KIND_UP);
				end
			end
			KIND_RUN: active_d = 1'b1;
			KIND_PAUSE: active_d = 1'b0;
			KIND_CLEAR: begin
				tmr_d = '0;
				active_d = 1'b0;
			end
			default: ;
		endcase
	end

	// result from the state after the event
	always_comb begin
		res.expired = expired;
		res.running = active_d;
		res.rem_s = tmr_d.s;
		res.rem_m = tmr_d.m;
		res.rem_h = tmr_d.h;
		res.clk_s = clk_d.s;
		res.clk_m = clk_d.m;
		res.pm = 1'b0;
		res.shown_h = clk_d.h[4:0];
		if (!fmt24_q) begin
			if (clk_d.h[4:0] == 5'd0) begin
				res.shown_h = NOON;
			end else if (clk_d.h[4:0] == NOON) begin
				res.pm = 1'b1;
			end else if (clk_d.h[4:0] > NOON) begin
				res.shown_h = clk_d.h[4:0] - NOON;
				res.pm = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			fmt24_q <= 1'b1;
			tick_q <= '0;
			clk_q <= '0;
			tmr_q <= '0;
			active_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_TPS) begin
					tps_q <= cfg_wdata;
				end else if (cfg_idx == CFG_FMT24) begin
					fmt24_q <= cfg_wdata[0];
				end
			end
			if (in_fire) begin
				tick_q <= tick_d;
				clk_q <= clk_d;
				tmr_q <= tmr_d;
				active_q <= active_d;
			end
		end
	end

endmodule

/* hdl/cdt_out_buf.sv */
`timescale 1ns / 1ps
module cdt_out_buf import cdt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    has_room,
	output logic    dout_valid,
	input  logic    pop,
	output result_t dout
);

	// two-entry buffer: head feeds the port, tail catches a transfer during a stall
	result_t    head_q;
	result_t    tail_q;
	logic [1:0] count_q;

	assign has_room = (count_q != 2'd2);
	assign dout_valid = (count_q != 2'd0);
	assign dout = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (count_q == 2'd2) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= din;
			end else begin
				tail_q <= din;
			end
		end
	end

endmodule

/* hdl/clock_and_countdown_timer_unit.sv */
`timescale 1ns / 1ps
// Time-of-day clock (24-hour wrap) with a countdown timer of up to 99 hours. Every
// transfer on the s_ stream is one event (tick, adjust up or down, run, pause,
// clear) and yields exactly one m_ transfer with the clock and timer after that
// event. The carry and borrow chains settle in one pass from the state registers into
// a two-entry output buffer, so a new event is taken every cycle while m_tready keeps
// up, and input stalls only once two results wait.
// Registers: index 0 ticks per second (reset 3000), index 1 selects the 24-hour form
// (reset 1); other indexes are ignored. Write them only while the block is idle.
module clock_and_countdown_timer_unit import cdt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,    // kind[2:0], target[5:3]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// shown_hours[4:0], pm_flag[5], clock_minutes[11:6], clock_seconds[17:12],
	// remaining_hours[24:18], remaining_minutes[30:25], remaining_seconds[36:31],
	// running_flag[37], expired_pulse[38]
	output logic [39:0]          m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	result_t res;
	result_t head;
	logic    in_fire;
	logic    out_fire;

	assign cfg_ready = 1'b1;
	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	cdt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.in_fire   (in_fire),
		.in_kind   (s_tdata[2:0]),
		.in_target (s_tdata[5:3]),
		.res       (res)
	);

	cdt_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_fire),
		.din        (res),
		.has_room   (s_tready),
		.dout_valid (m_tvalid),
		.pop        (out_fire),
		.dout       (head)
	);

	assign m_tdata = {1'b0, head};

endmodule

/* hdl/cdt_checker.sv */
`timescale 1ns / 1ps
`include "clock_and_countdown_timer_unit_assert.svh"
module cdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic tmr_zero;
	logic clk_ok;
	logic tmr_ok;
	logic pm_hour_ok;

	assign tmr_zero = (m_tdata[36:18] == 19'd0);
	assign clk_ok = (m_tdata[11:6] <= 6'd59) && (m_tdata[17:12] <= 6'd59);
	assign tmr_ok = (m_tdata[24:18] <= 7'd99) && (m_tdata[30:25] <= 6'd59) &&
		(m_tdata[36:31] <= 6'd59);
	assign pm_hour_ok = (m_tdata[4:0] >= 5'd1) && (m_tdata[4:0] <= 5'd12);

	// a stalled result holds
	`CDT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// expiry leaves the timer stopped at zero
	`CDT_ASSERT_IMPLY(a_expire_zero, clk, arst_n, m_tvalid && m_tdata[38], !m_tdata[37] && tmr_zero)

	// counters stay in range
	`CDT_ASSERT_IMPLY(a_ranges, clk, arst_n, m_tvalid, clk_ok && tmr_ok)

	// afternoon hours show as 1 to 12
	`CDT_ASSERT_IMPLY(a_pm_hours, clk, arst_n, m_tvalid && m_tdata[5], pm_hour_ok)

endmodule

bind clock_and_countdown_timer_unit cdt_checker u_cdt_checker (.*);

/* test/clock_timer_checker.sv */
`timescale 1ns / 1ps
module clock_timer_checker import cdt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [39:0]          m_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int SECS_PER_HOUR = 3600;
	localparam int CLOCK_SPAN = int'(CLK_HMOD) * SECS_PER_HOUR;
	localparam int TIMER_SPAN = int'(TMR_HMOD) * SECS_PER_HOUR;

	typedef struct {
		logic [4:0] shown_hours;
		logic       pm_flag;
		logic [5:0] clock_minutes;
		logic [5:0] clock_seconds;
		logic [6:0] remaining_hours;
		logic [5:0] remaining_minutes;
		logic [5:0] remaining_seconds;
		logic       running_flag;
		logic       expired_pulse;
	} readout_t;

	logic [TICK_W-1:0] ticks_per_sec;
	logic              hour24;
	logic [TICK_W-1:0] tick_cnt;
	// both counters are kept as plain seconds, clock since midnight
	int                clock_secs;
	int                timer_secs;
	logic              counting_down;
	readout_t          readout_q[$];
	int                n_bad;

	initial n_bad = 0;

	function automatic int wrap_secs(int v, int span);
		return ((v % span) + span) % span;
	endfunction

	function automatic int unit_weight(logic [2:0] target);
		case (target)
			TGT_CLK_H, TGT_TMR_H: return SECS_PER_HOUR;
			TGT_CLK_M, TGT_TMR_M: return 60;
			default: return 1;
		endcase
	endfunction

	// applies one event to the clock and timer and returns what the block shows after it
	function automatic readout_t apply_event(logic [2:0] kind, logic [2:0] target);
		readout_t r;
		int step;
		int hrs;
		int shown;
		r.expired_pulse = 1'b0;
		step = (kind == KIND_UP) ? unit_weight(target) : -unit_weight(target);
		case (kind)
			KIND_TICK: begin
				if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, ticks_per_sec}) begin
					tick_cnt = '0;
					clock_secs = wrap_secs(clock_secs + 1, CLOCK_SPAN);
					if (counting_down) begin
						if (timer_secs == 0) begin
							counting_down = 1'b0;
							r.expired_pulse = 1'b1;
						end else begin
							timer_secs = timer_secs - 1;
						end
					end
				end else begin
					tick_cnt = tick_cnt + 1'b1;
				end
			end
			KIND_UP, KIND_DOWN: begin
				if (target <= TGT_CLK_S) begin
					clock_secs = wrap_secs(clock_secs + step, CLOCK_SPAN);
				end else if (target <= TGT_TMR_S) begin
					timer_secs = wrap_secs(timer_secs + step, TIMER_SPAN);
				end
			end
			KIND_RUN: counting_down = 1'b1;
			KIND_PAUSE: counting_down = 1'b0;
			KIND_CLEAR: begin
				timer_secs = 0;
				counting_down = 1'b0;
			end
			default: ;
		endcase

		hrs = clock_secs / SECS_PER_HOUR;
		r.pm_flag = !hour24 && hrs >= int'(NOON);
		if (hour24) begin
			shown = hrs;
		end else if (hrs == 0) begin
			shown = int'(NOON);
		end else if (hrs > int'(NOON)) begin
			shown = hrs - int'(NOON);
		end else begin
			shown = hrs;
		end
		r.shown_hours = 5'(shown);
		r.clock_minutes = 6'((clock_secs / 60) % 60);
		r.clock_seconds = 6'(clock_secs % 60);
		r.remaining_hours = 7'(timer_secs / SECS_PER_HOUR);
		r.remaining_minutes = 6'((timer_secs / 60) % 60);
		r.remaining_seconds = 6'(timer_secs % 60);
		r.running_flag = counting_down;
		return r;
	endfunction

	function automatic readout_t unpack_readout(logic [39:0] d);
		readout_t r;
		r.shown_hours = d[4:0];
		r.pm_flag = d[5];
		r.clock_minutes = d[11:6];
		r.clock_seconds = d[17:12];
		r.remaining_hours = d[24:18];
		r.remaining_minutes = d[30:25];
		r.remaining_seconds = d[36:31];
		r.running_flag = d[37];
		r.expired_pulse = d[38];
		return r;
	endfunction

	task automatic check_field(string fname, int want_v, int got_v);
		if (want_v != got_v) begin
			n_bad++;
			if (n_bad <= 10)
				$display("%0t mismatch on %s: expected %0d, got %0d", $time, fname, want_v,
					got_v);
		end
	endtask

	task automatic compare_readout(readout_t want, readout_t got);
		check_field("shown_hours", want.shown_hours, got.shown_hours);
		check_field("pm_flag", want.pm_flag, got.pm_flag);
		check_field("clock_minutes", want.clock_minutes, got.clock_minutes);
		check_field("clock_seconds", want.clock_seconds, got.clock_seconds);
		check_field("remaining_hours", want.remaining_hours, got.remaining_hours);
		check_field("remaining_minutes", want.remaining_minutes, got.remaining_minutes);
		check_field("remaining_seconds", want.remaining_seconds, got.remaining_seconds);
		check_field("running_flag", want.running_flag, got.running_flag);
		check_field("expired_pulse", want.expired_pulse, got.expired_pulse);
	endtask

	always @(posedge clk or negedge arst_n) begin
		readout_t want;
		if (!arst_n) begin
			ticks_per_sec = TPS_RESET;
			hour24 = 1'b1;
			tick_cnt = '0;
			clock_secs = 0;
			timer_secs = 0;
			counting_down = 1'b1;
			readout_q.delete();
			outstanding <= 0;
			mismatches <= n_bad;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TPS)
					ticks_per_sec = cfg_data;
				else if (cfg_index == CFG_FMT24)
					hour24 = cfg_data[0];
			end
			if (s_tvalid && s_tready)
				readout_q.push_back(apply_event(s_tdata[2:0], s_tdata[5:3]));
			if (m_tvalid && m_tready) begin
				if (readout_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t result transfer with nothing pending: %h", $time, m_tdata);
				end else begin
					want = readout_q.pop_front();
					compare_readout(want, unpack_readout(m_tdata));
				end
			end
			outstanding <= readout_q.size();
			mismatches <= n_bad;
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import cdt_pkg::*;

	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam logic [2:0] TGT_SPARE_A = 3'd6;
	localparam logic [2:0] TGT_SPARE_B = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;

	localparam int MAX_GAP = 17;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT_RESULT = 120;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 60;
	localparam int N_PHASES = 6;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;    // kind[2:0], target[5:3]
	logic                 m_tvalid;
	logic                 m_tready;
	// shown_hours[4:0], pm_flag[5], clock_minutes[11:6], clock_seconds[17:12],
	// remaining_hours[24:18], remaining_minutes[30:25], remaining_seconds[36:31],
	// running_flag[37], expired_pulse[38]
	logic [39:0]          m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;
	int                   mismatches;
	int                   outstanding;

	bit brisk = 1'b0;    // both sides skip idling
	int quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	clock_and_countdown_timer_unit u_dut (.*);

	clock_timer_checker u_checker (.*);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stalls, one long hold-off so the input backs up
	initial begin
		int stall;
		int results_seen;
		bit held;
		results_seen = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AT_RESULT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = brisk ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
		end
	end

	task automatic send_event(input logic [2:0] kind, input logic [2:0] target);
		int gap;
		gap = brisk ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, target, kind};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [TICK_W-1:0] tps, input logic fmt24,
			input bit poke_unused);
		wait_idle();
		write_reg(CFG_TPS, tps);
		// upper data bits are don't-care for the format register
		write_reg(CFG_FMT24, {15'($urandom), fmt24});
		if (poke_unused)
			write_reg(CFG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random();
		int pick;
		int n;
		logic [2:0] kind;
		logic [2:0] target;
		pick = $urandom_range(0, 99);
		target = 3'($urandom_range(0, 5));
		kind = KIND_TICK;
		if (pick < 8) begin
			// load a short countdown and start it, so expiry comes up often
			send_event(KIND_CLEAR, 3'($urandom_range(0, 7)));
			n = $urandom_range(0, 3);
			repeat (n) send_event(KIND_UP, TGT_TMR_S);
			kind = KIND_RUN;
		end else if (pick < 50) begin
			kind = KIND_TICK;
		end else if (pick < 63) begin
			kind = KIND_UP;
		end else if (pick < 76) begin
			kind = KIND_DOWN;
		end else if (pick < 82) begin
			kind = KIND_RUN;
		end else if (pick < 86) begin
			kind = KIND_PAUSE;
		end else if (pick < 89) begin
			kind = KIND_CLEAR;
		end else if (pick < 95) begin
			kind = 3'($urandom_range(0, 7));
			target = 3'($urandom_range(0, 7));
		end else begin
			kind = pick[0] ? KIND_UP : KIND_DOWN;
			target = pick[1] ? TGT_SPARE_A : TGT_SPARE_B;
		end
		send_event(kind, target);
	endtask

	initial begin
		logic [TICK_W-1:0] phase_tps [N_PHASES];
		logic              phase_fmt [N_PHASES];
		phase_tps = '{16'd2, 16'd1, 16'd65535, 16'd3, 16'd0, 16'($urandom_range(1, 8))};
		phase_fmt = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: slow timebase, unknown kinds and targets
		send_event(KIND_TICK, TGT_CLK_H);
		send_event(KIND_SPARE_A, TGT_TMR_S);
		send_event(KIND_SPARE_B, TGT_SPARE_B);
		send_event(KIND_UP, TGT_SPARE_A);
		send_event(KIND_DOWN, TGT_SPARE_B);

		configure(16'd1, 1'b0, 1'b0);
		send_event(KIND_TICK, TGT_SPARE_B);   // running timer at zero expires
		send_event(KIND_DOWN, TGT_CLK_S);     // seconds step back down to 00:00:00
		send_event(KIND_TICK, TGT_CLK_H);     // clock steps to 00:00:01
		send_event(KIND_DOWN, TGT_CLK_H);
		send_event(KIND_DOWN, TGT_CLK_H);
		send_event(KIND_UP, TGT_CLK_M);
		send_event(KIND_DOWN, TGT_TMR_S);     // timer wraps down to 99:59:59
		send_event(KIND_UP, TGT_TMR_S);
		send_event(KIND_DOWN, TGT_TMR_H);
		send_event(KIND_UP, TGT_TMR_M);
		send_event(KIND_UP, TGT_TMR_H);       // timer hours wrap up to 0
		send_event(KIND_RUN, TGT_CLK_M);
		send_event(KIND_TICK, TGT_TMR_H);
		send_event(KIND_PAUSE, TGT_CLK_S);
		send_event(KIND_TICK, TGT_TMR_M);
		send_event(KIND_CLEAR, TGT_TMR_S);
		send_event(KIND_RUN, TGT_CLK_H);      // run on a zero timer
		send_event(KIND_TICK, TGT_CLK_H);
		send_event(KIND_UP, TGT_CLK_H);

		for (int p = 0; p < N_PHASES; p++) begin
			configure(phase_tps[p], phase_fmt[p], p == 2);
			brisk = (p == 1 || p == 4);
			repeat (PHASE_ITEMS) send_random();
			brisk = 1'b0;
		end

		wait_idle();
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cdt_pkg.sv
hdl/cdt_core.sv
hdl/cdt_out_buf.sv
hdl/clock_and_countdown_timer_unit.sv
hdl/cdt_checker.sv
test/clock_timer_checker.sv
test/testbench.sv
